// ===== src/gbrm_pkg.sv =====
// Shared types and constants for the gated bit range mapper.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package gbrm_pkg;

   localparam int NUM_ENTRIES_DEF = 32;
   localparam int STORE_BYTES_DEF = 64;
   localparam int NUM_OUTPUTS_DEF = 25;

   localparam int CSR_W   = 6;
   localparam int INDEX_W = 9;
   localparam int WORD_W  = 32;

   localparam logic [1:0] FUNC_STOP = 2'd0;
   localparam logic [1:0] FUNC_KEY  = 2'd1;
   localparam logic [1:0] FUNC_MAP  = 2'd2;

   typedef struct packed {
      logic [INDEX_W-1:0] start_bit;
      logic [INDEX_W-1:0] end_bit;
      logic signed [7:0]  shift_amount;
      logic [INDEX_W-1:0] gate_index;
      logic [INDEX_W-1:0] and_index;
      logic [INDEX_W-1:0] nand_index;
      logic               ungated;
      logic               is_coupler;
   } map_entry_type;

endpackage

`default_nettype wire

// ===== src/gbrm_ifs.sv =====
// Valid/ready channel interfaces for the gated bit range mapper.
// Depends on gbrm_pkg for field widths.
`default_nettype none

interface gbrm_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     func;
   logic [4:0]                     slot;
   logic [gbrm_pkg::WORD_W-1:0]    data_word;
   logic [gbrm_pkg::INDEX_W-1:0]   start_bit;
   logic [gbrm_pkg::INDEX_W-1:0]   end_bit;
   logic signed [7:0]              shift_amount;
   logic [gbrm_pkg::INDEX_W-1:0]   gate_index;
   logic [gbrm_pkg::INDEX_W-1:0]   and_index;
   logic [gbrm_pkg::INDEX_W-1:0]   nand_index;
   logic                           ungated;
   logic                           is_coupler;

   modport source (output valid, func, slot, data_word, start_bit, end_bit, shift_amount,
                   gate_index, and_index, nand_index, ungated, is_coupler, input ready);
   modport sink (input valid, func, slot, data_word, start_bit, end_bit, shift_amount,
                 gate_index, and_index, nand_index, ungated, is_coupler, output ready);
endinterface

interface gbrm_rsp_if #(parameter int NUM_OUTPUTS = gbrm_pkg::NUM_OUTPUTS_DEF);
   logic                   valid;
   logic                   ready;
   logic [NUM_OUTPUTS-1:0] drive_pattern;

   modport source (output valid, drive_pattern, input ready);
   modport sink (input valid, drive_pattern, output ready);
endinterface

interface gbrm_csr_if;
   logic                       valid;
   logic                       ready;
   logic [gbrm_pkg::CSR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/gbrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gbrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/gated_bit_range_mapper.sv =====
// Top level of the gated bit range mapper: key, stop and mapping stores and the entry walker.
// Depends on gbrm_pkg, the channel interfaces in gbrm_ifs and gbrm_ram.
//
//   Channel    Dir  Word                                   Accepted when
//   req_chan   in   func, slot, store data, entry fields   valid & ready
//   rsp_chan   out  drive_pattern                          valid & ready
//   csr_chan   in   valid_blocks                           valid & ready (ready always high)
//
// A table write gives no word. A store write gives one drive pattern: the walker
// reads min(valid_blocks, NUM_ENTRIES) mapping entries from the table RAM, one per
// cycle, and each entry then passes three pipeline stages. Reset clears the valid
// bits of all stores at once.
// While a finished pattern waits on rsp_chan the next word is taken in, and its
// result waits, with req_chan not ready, until the output register is free.
`default_nettype none

module gated_bit_range_mapper #(
   parameter int NUM_ENTRIES = gbrm_pkg::NUM_ENTRIES_DEF,
   parameter int STORE_BYTES = gbrm_pkg::STORE_BYTES_DEF,
   parameter int NUM_OUTPUTS = gbrm_pkg::NUM_OUTPUTS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   gbrm_req_if.sink       req_chan,
   gbrm_rsp_if.source     rsp_chan,
   gbrm_csr_if.sink       csr_chan
);

   localparam int NUM_WORDS = (STORE_BYTES + 3) / 4;
   localparam int WAW = $clog2(NUM_WORDS);
   localparam int EAW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CW = $clog2(NUM_ENTRIES + 1);
   localparam int ENTRY_W = $bits(gbrm_pkg::map_entry_type);
   localparam int WW = gbrm_pkg::WORD_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   function automatic logic [WW-1:0] word_mask(input logic [4:0] word);
      logic [WW-1:0] m;
      m = '0;
      for (int j = 0; j < 4; j++) begin
         if (4 * int'(word) + j < STORE_BYTES) begin
            m[8*j +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   state_type                    state_ff, state_in;
   logic [gbrm_pkg::CSR_W-1:0]   vblk_ff, vblk_in;
   logic [NUM_WORDS-1:0]         key_vld_ff, key_vld_in;
   logic [NUM_WORDS-1:0]         stop_vld_ff, stop_vld_in;
   logic [NUM_ENTRIES-1:0]       tbl_vld_ff, tbl_vld_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                used_ff, used_in;
   logic                         s1_v_ff, s1_v_in;
   logic [EAW-1:0]               s1_idx_ff, s1_idx_in;
   logic                         s2_v_ff, s2_v_in;
   logic [4:0]                   s2_bofs_ff, s2_bofs_in;
   logic [4:0]                   s2_klo_ff, s2_klo_in;
   logic [4:0]                   s2_khi_ff, s2_khi_in;
   logic [4:0]                   s2_gw_ff, s2_gw_in;
   logic [4:0]                   s2_gb_ff, s2_gb_in;
   logic [4:0]                   s2_sw_ff, s2_sw_in;
   logic [4:0]                   s2_sb_ff, s2_sb_in;
   logic signed [9:0]            s2_span_ff, s2_span_in;
   logic signed [7:0]            s2_off_ff, s2_off_in;
   logic                         s2_ung_ff, s2_ung_in;
   logic                         s2_cpl_ff, s2_cpl_in;
   logic                         s3_v_ff, s3_v_in;
   logic [NUM_OUTPUTS-1:0]       s3_taken_ff, s3_taken_in;
   logic signed [7:0]            s3_off_ff, s3_off_in;
   logic [NUM_OUTPUTS-1:0]       acc_ff, acc_in;
   logic                         rsp_v_ff, rsp_v_in;
   logic [NUM_OUTPUTS-1:0]       rsp_data_ff, rsp_data_in;

   logic                         accept;
   logic                         is_store;
   logic                         tbl_we;
   logic                         key_we;
   logic                         stop_we;
   logic                         issue;
   gbrm_pkg::map_entry_type      tbl_wdata;
   gbrm_pkg::map_entry_type      entry;
   logic [ENTRY_W-1:0]           tbl_rdata;
   logic [WW-1:0]                key_lo_rdata, key_hi_rdata;
   logic [WW-1:0]                stop_g_rdata, stop_s_rdata;
   logic [WW-1:0]                key_lo_word, key_hi_word;
   logic [WW-1:0]                stop_g_word, stop_s_word;
   logic [2*WW-1:0]              key_window;
   logic [8:0]                   sel_index;
   logic                         gate_on, sel_on, active;
   logic [7:0]                   off_mag;
   logic [NUM_OUTPUTS-1:0]       shifted;

   assign accept = req_chan.valid && req_chan.ready;
   assign is_store = (req_chan.func == gbrm_pkg::FUNC_STOP) ||
                     (req_chan.func == gbrm_pkg::FUNC_KEY);
   assign tbl_we = accept && (req_chan.func == gbrm_pkg::FUNC_MAP) &&
                   (int'(req_chan.slot) < NUM_ENTRIES);
   assign key_we = accept && (req_chan.func == gbrm_pkg::FUNC_KEY) &&
                   (int'(req_chan.slot) < NUM_WORDS);
   assign stop_we = accept && (req_chan.func == gbrm_pkg::FUNC_STOP) &&
                    (int'(req_chan.slot) < NUM_WORDS);
   assign issue = (state_ff == ST_WALK) && (idx_ff < used_ff);

   assign tbl_wdata.start_bit    = req_chan.start_bit;
   assign tbl_wdata.end_bit      = req_chan.end_bit;
   assign tbl_wdata.shift_amount = req_chan.shift_amount;
   assign tbl_wdata.gate_index   = req_chan.gate_index;
   assign tbl_wdata.and_index    = req_chan.and_index;
   assign tbl_wdata.nand_index   = req_chan.nand_index;
   assign tbl_wdata.ungated      = req_chan.ungated;
   assign tbl_wdata.is_coupler   = req_chan.is_coupler;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_v_ff;
   assign rsp_chan.drive_pattern = rsp_data_ff;

   assign entry = tbl_vld_ff[s1_idx_ff] ? gbrm_pkg::map_entry_type'(tbl_rdata) : '0;
   assign sel_index = entry.is_coupler ? entry.and_index : entry.nand_index;

   gbrm_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_ENTRIES)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (EAW'(req_chan.slot)),
      .wr_data (tbl_wdata),
      .rd_addr (idx_ff[EAW-1:0]),
      .rd_data (tbl_rdata)
   );

   gbrm_ram #(.WIDTH(WW), .DEPTH(NUM_WORDS)) u_key_lo_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (WAW'(req_chan.slot)),
      .wr_data (req_chan.data_word),
      .rd_addr (WAW'(entry.start_bit[8:5])),
      .rd_data (key_lo_rdata)
   );

   gbrm_ram #(.WIDTH(WW), .DEPTH(NUM_WORDS)) u_key_hi_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (WAW'(req_chan.slot)),
      .wr_data (req_chan.data_word),
      .rd_addr (WAW'({1'b0, entry.start_bit[8:5]} + 5'd1)),
      .rd_data (key_hi_rdata)
   );

   gbrm_ram #(.WIDTH(WW), .DEPTH(NUM_WORDS)) u_stop_g_ram (
      .clock   (clock),
      .wr_en   (stop_we),
      .wr_addr (WAW'(req_chan.slot)),
      .wr_data (req_chan.data_word),
      .rd_addr (WAW'(entry.gate_index[8:5])),
      .rd_data (stop_g_rdata)
   );

   gbrm_ram #(.WIDTH(WW), .DEPTH(NUM_WORDS)) u_stop_s_ram (
      .clock   (clock),
      .wr_en   (stop_we),
      .wr_addr (WAW'(req_chan.slot)),
      .wr_data (req_chan.data_word),
      .rd_addr (WAW'(sel_index[8:5])),
      .rd_data (stop_s_rdata)
   );

   always_comb begin
      key_lo_word = key_lo_rdata & word_mask(s2_klo_ff) & {WW{key_vld_ff[WAW'(s2_klo_ff)]}};
      key_hi_word = key_hi_rdata & word_mask(s2_khi_ff) & {WW{key_vld_ff[WAW'(s2_khi_ff)]}};
      stop_g_word = stop_g_rdata & word_mask(s2_gw_ff) & {WW{stop_vld_ff[WAW'(s2_gw_ff)]}};
      stop_s_word = stop_s_rdata & word_mask(s2_sw_ff) & {WW{stop_vld_ff[WAW'(s2_sw_ff)]}};
      key_window = {key_hi_word, key_lo_word} >> s2_bofs_ff;
      gate_on = stop_g_word[s2_gb_ff];
      sel_on = stop_s_word[s2_sb_ff];
      active = s2_ung_ff || (gate_on && (s2_cpl_ff ? sel_on : !sel_on));
      off_mag = ~s3_off_ff + 8'd1;
      if (s3_off_ff[7]) begin
         shifted = s3_taken_ff >> off_mag;
      end else begin
         shifted = s3_taken_ff << s3_off_ff[6:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      vblk_in = vblk_ff;
      key_vld_in = key_vld_ff;
      stop_vld_in = stop_vld_ff;
      tbl_vld_in = tbl_vld_ff;
      idx_in = idx_ff;
      used_in = used_ff;
      acc_in = acc_ff;
      rsp_v_in = rsp_v_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_chan.valid && csr_chan.ready) begin
         vblk_in = csr_chan.data;
      end
      if (key_we) begin
         key_vld_in[WAW'(req_chan.slot)] = 1'b1;
      end
      if (stop_we) begin
         stop_vld_in[WAW'(req_chan.slot)] = 1'b1;
      end
      if (tbl_we) begin
         tbl_vld_in[EAW'(req_chan.slot)] = 1'b1;
      end
      if (rsp_v_ff && rsp_chan.ready) begin
         rsp_v_in = 1'b0;
      end

      s1_v_in = issue;
      s1_idx_in = idx_ff[EAW-1:0];
      if (issue) begin
         idx_in = idx_ff + CW'(1);
      end

      s2_v_in = s1_v_ff;
      s2_bofs_in = entry.start_bit[4:0];
      s2_klo_in = {1'b0, entry.start_bit[8:5]};
      s2_khi_in = {1'b0, entry.start_bit[8:5]} + 5'd1;
      s2_gw_in = {1'b0, entry.gate_index[8:5]};
      s2_gb_in = entry.gate_index[4:0];
      s2_sw_in = {1'b0, sel_index[8:5]};
      s2_sb_in = sel_index[4:0];
      s2_span_in = $signed({1'b0, entry.end_bit}) - $signed({1'b0, entry.start_bit});
      s2_off_in = entry.shift_amount;
      s2_ung_in = entry.ungated;
      s2_cpl_in = entry.is_coupler;

      s3_v_in = s2_v_ff;
      s3_off_in = s2_off_ff;
      for (int k = 0; k < NUM_OUTPUTS; k++) begin
         s3_taken_in[k] = active && key_window[k] &&
                          ((k == 0) || (s2_span_ff >= $signed(10'(k))));
      end

      if (s3_v_ff) begin
         acc_in = acc_ff | shifted;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_store) begin
               state_in = ST_WALK;
               idx_in = '0;
               acc_in = '0;
               if (int'(vblk_ff) > NUM_ENTRIES) begin
                  used_in = CW'(NUM_ENTRIES);
               end else begin
                  used_in = CW'(vblk_ff);
               end
            end
         end
         ST_WALK: begin
            if (!issue && !s1_v_ff && !s2_v_ff && !s3_v_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_v_ff || rsp_chan.ready) begin
               rsp_v_in = 1'b1;
               rsp_data_in = acc_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vblk_ff <= '0;
         key_vld_ff <= '0;
         stop_vld_ff <= '0;
         tbl_vld_ff <= '0;
         idx_ff <= '0;
         used_ff <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vblk_ff <= vblk_in;
         key_vld_ff <= key_vld_in;
         stop_vld_ff <= stop_vld_in;
         tbl_vld_ff <= tbl_vld_in;
         idx_ff <= idx_in;
         used_ff <= used_in;
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
      s1_idx_ff <= s1_idx_in;
      s2_bofs_ff <= s2_bofs_in;
      s2_klo_ff <= s2_klo_in;
      s2_khi_ff <= s2_khi_in;
      s2_gw_ff <= s2_gw_in;
      s2_gb_ff <= s2_gb_in;
      s2_sw_ff <= s2_sw_in;
      s2_sb_ff <= s2_sb_in;
      s2_span_ff <= s2_span_in;
      s2_off_ff <= s2_off_in;
      s2_ung_ff <= s2_ung_in;
      s2_cpl_ff <= s2_cpl_in;
      s3_taken_ff <= s3_taken_in;
      s3_off_ff <= s3_off_in;
      acc_ff <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== tb/tb_gated_bit_range_mapper.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gated_bit_range_mapper: directed and random store and table words.
// Predicts every drive pattern in its own model and checks it; needs gbrm_pkg and gbrm_ifs.

module tb_gated_bit_range_mapper;

   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int STORE_BITS = gbrm_pkg::STORE_BYTES_DEF * 8;

   typedef struct packed {
      logic [1:0]              func;
      logic [4:0]              slot;
      logic [31:0]             data_word;
      gbrm_pkg::map_entry_type entry;
   } word_type;

   logic clock;
   logic reset;

   gbrm_req_if req_chan ();
   gbrm_rsp_if rsp_chan ();
   gbrm_csr_if csr_chan ();

   gated_bit_range_mapper dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   word_type                              pending_words[$];
   logic [gbrm_pkg::NUM_OUTPUTS_DEF-1:0]  drive_expect[$];
   word_type                              cur_word;

   logic [STORE_BITS-1:0]                 key_bits;
   logic [STORE_BITS-1:0]                 stop_bits;
   gbrm_pkg::map_entry_type               map_rows[gbrm_pkg::NUM_ENTRIES_DEF];
   int                                    block_count;

   int   error_count;
   int   burst_left;
   int   gap_left;
   logic sender_steady;
   logic hold_rsp;
   logic long_hold_go;
   int   rsp_tick;
   int   stall_mode;

   always #1 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic key_bit(input int idx);
      return (idx < STORE_BITS) ? key_bits[idx] : 1'b0;
   endfunction

   function automatic logic stop_bit(input int idx);
      return (idx < STORE_BITS) ? stop_bits[idx] : 1'b0;
   endfunction

   function automatic logic [gbrm_pkg::NUM_OUTPUTS_DEF-1:0] rebuild_drive();
      logic [gbrm_pkg::NUM_OUTPUTS_DEF-1:0] pat;
      gbrm_pkg::map_entry_type m;
      logic active;
      int used;
      int s;
      int span;
      int shift;
      int pos;
      pat = '0;
      used = (block_count > gbrm_pkg::NUM_ENTRIES_DEF) ? gbrm_pkg::NUM_ENTRIES_DEF : block_count;
      for (int e = 0; e < used; e++) begin
         m = map_rows[e];
         if (m.ungated) begin
            active = 1'b1;
         end else begin
            active = stop_bit(m.gate_index) &&
                     ((m.is_coupler && stop_bit(m.and_index)) ||
                      (!m.is_coupler && !stop_bit(m.nand_index)));
         end
         if (active) begin
            s = m.start_bit;
            span = m.end_bit;
            span = span - s;
            shift = m.shift_amount;
            for (int k = 0; k < gbrm_pkg::NUM_OUTPUTS_DEF; k++) begin
               if ((k == 0 || span >= k) && key_bit(s + k)) begin
                  pos = k + shift;
                  if (pos >= 0 && pos < gbrm_pkg::NUM_OUTPUTS_DEF) pat[pos] = 1'b1;
               end
            end
         end
      end
      return pat;
   endfunction

   function automatic void apply_word(input word_type w);
      int idx;
      unique case (w.func)
         gbrm_pkg::FUNC_MAP: begin
            if (w.slot < gbrm_pkg::NUM_ENTRIES_DEF) map_rows[w.slot] = w.entry;
         end
         gbrm_pkg::FUNC_KEY, gbrm_pkg::FUNC_STOP: begin
            for (int j = 0; j < 4; j++) begin
               idx = w.slot;
               idx = idx * 4 + j;
               if (idx < gbrm_pkg::STORE_BYTES_DEF) begin
                  if (w.func == gbrm_pkg::FUNC_KEY) key_bits[idx*8 +: 8] = w.data_word[j*8 +: 8];
                  else stop_bits[idx*8 +: 8] = w.data_word[j*8 +: 8];
               end
            end
            drive_expect.push_back(rebuild_drive());
         end
         default: begin
         end
      endcase
   endfunction

   function automatic word_type store_word(input logic [1:0] func, input int slot,
                                           input logic [31:0] data);
      word_type w;
      w = '0;
      w.func = func;
      w.slot = slot[4:0];
      w.data_word = data;
      return w;
   endfunction

   function automatic word_type map_word(input int slot, input int start, input int stop,
                                         input int shift, input int gate, input int and_bit,
                                         input int nand_bit, input logic ungated,
                                         input logic coupler);
      word_type w;
      w = '0;
      w.func = gbrm_pkg::FUNC_MAP;
      w.slot = slot[4:0];
      w.entry.start_bit = start[8:0];
      w.entry.end_bit = stop[8:0];
      w.entry.shift_amount = shift[7:0];
      w.entry.gate_index = gate[8:0];
      w.entry.and_index = and_bit[8:0];
      w.entry.nand_index = nand_bit[8:0];
      w.entry.ungated = ungated;
      w.entry.is_coupler = coupler;
      return w;
   endfunction

   function automatic word_type random_word();
      word_type w;
      int pick;
      w.data_word = ($urandom_range(3) == 0) ? ($urandom & $urandom) : $urandom;
      w.entry.start_bit = 9'($urandom_range(STORE_BITS - 1));
      if ($urandom_range(4) == 0) w.entry.end_bit = 9'($urandom_range(STORE_BITS - 1));
      else w.entry.end_bit = 9'(w.entry.start_bit + $urandom_range(30));
      if ($urandom_range(9) < 3) w.entry.shift_amount = 8'($urandom_range(255));
      else w.entry.shift_amount = 8'($urandom_range(40) - 20);
      w.entry.gate_index = 9'($urandom_range(STORE_BITS - 1));
      w.entry.and_index = 9'($urandom_range(STORE_BITS - 1));
      w.entry.nand_index = 9'($urandom_range(STORE_BITS - 1));
      w.entry.ungated = ($urandom_range(9) < 3);
      w.entry.is_coupler = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 34) begin
         w.func = gbrm_pkg::FUNC_MAP;
         w.slot = 5'($urandom_range(gbrm_pkg::NUM_ENTRIES_DEF - 1));
      end else begin
         if (pick < 65) w.func = gbrm_pkg::FUNC_KEY;
         else if (pick < 97) w.func = gbrm_pkg::FUNC_STOP;
         else w.func = FUNC_SPARE;
         w.slot = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(15));
      end
      return w;
   endfunction

   always @(posedge clock) begin : driver
      word_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) apply_word(cur_word);
         if (!req_chan.valid || req_chan.ready) begin
            if (!sender_steady && gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               nxt = pending_words.pop_front();
               cur_word = nxt;
               req_chan.func <= nxt.func;
               req_chan.slot <= nxt.slot;
               req_chan.data_word <= nxt.data_word;
               req_chan.start_bit <= nxt.entry.start_bit;
               req_chan.end_bit <= nxt.entry.end_bit;
               req_chan.shift_amount <= nxt.entry.shift_amount;
               req_chan.gate_index <= nxt.entry.gate_index;
               req_chan.and_index <= nxt.entry.and_index;
               req_chan.nand_index <= nxt.entry.nand_index;
               req_chan.ungated <= nxt.entry.ungated;
               req_chan.is_coupler <= nxt.entry.is_coupler;
               req_chan.valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic [gbrm_pkg::NUM_OUTPUTS_DEF-1:0] want;
      logic take;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (drive_expect.size() == 0) begin
               report_error($sformatf("drive pattern %h with none expected",
                                      rsp_chan.drive_pattern));
            end else begin
               want = drive_expect.pop_front();
               if (rsp_chan.drive_pattern !== want)
                  report_error($sformatf("drive_pattern %h, expected %h",
                                         rsp_chan.drive_pattern, want));
            end
         end
         rsp_tick++;
         if (rsp_tick % 64 == 0) stall_mode = $urandom_range(3);
         unique case (stall_mode)
            0: take = 1'b1;
            1: take = 1'($urandom_range(1));
            2: take = ($urandom_range(3) == 0);
            default: take = (rsp_tick % 8) < 5;
         endcase
         rsp_chan.ready <= hold_rsp ? 1'b0 : take;
      end
   end

   initial begin : long_hold
      wait (long_hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      #1_200_000;
      $display("status: fail");
      $finish;
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_chan.valid || drive_expect.size() != 0);
      repeat (45) @(posedge clock);
   endtask

   task automatic set_block_count(input int count);
      csr_chan.valid <= 1'b1;
      csr_chan.data <= count[gbrm_pkg::CSR_W-1:0];
      do @(posedge clock);
      while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      block_count = count;
   endtask

   task automatic load_random(input int count);
      for (int i = 0; i < count; i++) pending_words.push_back(random_word());
   endtask

   initial begin : stimulus
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = gbrm_pkg::FUNC_STOP;
      req_chan.slot = '0;
      req_chan.data_word = '0;
      req_chan.start_bit = '0;
      req_chan.end_bit = '0;
      req_chan.shift_amount = '0;
      req_chan.gate_index = '0;
      req_chan.and_index = '0;
      req_chan.nand_index = '0;
      req_chan.ungated = 1'b0;
      req_chan.is_coupler = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      key_bits = '0;
      stop_bits = '0;
      for (int e = 0; e < gbrm_pkg::NUM_ENTRIES_DEF; e++) map_rows[e] = '0;
      block_count = 0;
      error_count = 0;
      burst_left = 1;
      gap_left = 0;
      sender_steady = 1'b0;
      hold_rsp = 1'b0;
      long_hold_go = 1'b0;
      rsp_tick = 0;
      stall_mode = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_block_count(4);
      pending_words.push_back(store_word(gbrm_pkg::FUNC_KEY, 0, 32'hFFFF_FFFF));
      pending_words.push_back(map_word(0, 0, 511, 0, 0, 0, 0, 1'b1, 1'b0));
      pending_words.push_back(map_word(1, 511, 0, -128, 511, 511, 0, 1'b0, 1'b1));
      pending_words.push_back(map_word(2, 500, 511, 127, 0, 0, 0, 1'b1, 1'b0));
      pending_words.push_back(map_word(3, 505, 511, -3, 0, 0, 1, 1'b0, 1'b0));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_KEY, 15, 32'hFFFF_FFFF));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_KEY, 15, 32'hA5A5_A5A5));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_STOP, 15, 32'hFFFF_FFFF));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_STOP, 0, 32'h0000_0001));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_STOP, 0, 32'h0000_0003));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_KEY, 16, 32'h1234_5678));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_KEY, 31, 32'hFFFF_FFFF));
      pending_words.push_back(store_word(FUNC_SPARE, 31, 32'hFFFF_FFFF));
      pending_words.push_back(map_word(3, 0, 24, 24, 0, 0, 0, 1'b1, 1'b0));
      pending_words.push_back(map_word(2, 0, 0, -1, 0, 2, 0, 1'b0, 1'b1));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_KEY, 0, 32'h8000_0001));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_STOP, 0, 32'h0000_0005));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_STOP, 0, 32'h0000_0000));
      pending_words.push_back(store_word(gbrm_pkg::FUNC_KEY, 3, 32'h0000_0000));
      wait_idle();

      set_block_count(0);
      load_random(100);
      wait_idle();

      set_block_count(32);
      load_random(600);
      wait_idle();

      set_block_count(63);
      sender_steady <= 1'b1;
      long_hold_go = 1'b1;
      load_random(300);
      wait_idle();
      sender_steady <= 1'b0;

      set_block_count(1);
      load_random(200);
      wait_idle();

      set_block_count($urandom_range(2, 31));
      load_random(350);
      wait_idle();

      set_block_count(33);
      load_random(350);
      wait_idle();

      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
